>>> rtl/core/lrk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lrk_pkg: shared types, constants and microcode for the Lorenz RK2 stepper
// Fixed-point format, register map, shared-unit opcodes and the step program.
// ---------------------------------------------------------------------------
package lrk_pkg;

    localparam int WORD_BITS = 32;                 // Q10.22 word
    localparam int FRAC_BITS = 22;
    localparam int TIME_BITS = WORD_BITS - 1;
    localparam int CFG_COUNT = 7;
    localparam int ADDR_BITS = $clog2(CFG_COUNT * 4);
    localparam int IDX_BITS  = ADDR_BITS - 2;

    localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    // elapsed time stops one bit below the time field's range
    localparam logic [TIME_BITS-1:0] TIME_LIMIT = {1'b0, {(TIME_BITS-1){1'b1}}};

    // reset values, nearest code
    localparam longint ONE = longint'(1) <<< FRAC_BITS;
    localparam logic signed [WORD_BITS-1:0] RST_SIGMA = WORD_BITS'(10 * ONE);
    localparam logic signed [WORD_BITS-1:0] RST_RHO   = WORD_BITS'(40 * ONE);
    localparam logic signed [WORD_BITS-1:0] RST_BETA  = WORD_BITS'((267 * ONE + 50) / 100);
    localparam logic [TIME_BITS-1:0]        RST_STEP  = TIME_BITS'((2 * ONE + 500) / 1000);
    localparam logic signed [WORD_BITS-1:0] RST_X     = WORD_BITS'((ONE + 50) / 100);
    localparam logic signed [WORD_BITS-1:0] RST_Y     = WORD_BITS'((ONE + 50) / 100);
    localparam logic signed [WORD_BITS-1:0] RST_Z     = '0;

    typedef enum logic [IDX_BITS-1:0] {
        REG_SIGMA, REG_RHO, REG_BETA, REG_STEP, REG_START_X, REG_START_Y, REG_START_Z
    } t_reg;

    typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_ADDH} t_op;

    typedef enum logic [3:0] {
        SRC_X, SRC_Y, SRC_Z, SRC_PX, SRC_PY, SRC_PZ, SRC_T0, SRC_T1,
        SRC_T2, SRC_KX, SRC_KY, SRC_KZ, SRC_SIG, SRC_RHO, SRC_BETA, SRC_H
    } t_src;

    typedef enum logic [3:0] {
        DST_X, DST_Y, DST_Z, DST_PX, DST_PY, DST_PZ,
        DST_T0, DST_T1, DST_T2, DST_KX, DST_KY, DST_KZ
    } t_dst;

    typedef struct packed {
        t_op  op;
        t_src a;
        t_src b;
        t_dst d;
    } t_uop;

    localparam int UCODE_LEN = 28;
    localparam int STEP_BITS = $clog2(UCODE_LEN);

    typedef struct packed {
        logic ready;   // idle, takes an input transaction
        logic exec;    // shared unit busy with uop
        logic last;    // final program step
        logic emit;    // result moves into the output register
        t_uop uop;
    } t_seq_ctl;

    // midpoint step program: slope at s, midpoint p, slope at p, update s
    function automatic t_uop ucode(input logic [STEP_BITS-1:0] step);
        t_uop u;
        unique case (step)
            5'd0:    u = '{OP_SUB,  SRC_Y,    SRC_X,  DST_T0};
            5'd1:    u = '{OP_MUL,  SRC_SIG,  SRC_T0, DST_T0};
            5'd2:    u = '{OP_SUB,  SRC_RHO,  SRC_Z,  DST_T1};
            5'd3:    u = '{OP_MUL,  SRC_T1,   SRC_X,  DST_T1};
            5'd4:    u = '{OP_SUB,  SRC_T1,   SRC_Y,  DST_T1};
            5'd5:    u = '{OP_MUL,  SRC_X,    SRC_Y,  DST_T2};
            5'd6:    u = '{OP_MUL,  SRC_BETA, SRC_Z,  DST_KZ};
            5'd7:    u = '{OP_SUB,  SRC_T2,   SRC_KZ, DST_T2};
            5'd8:    u = '{OP_MUL,  SRC_H,    SRC_T0, DST_KX};
            5'd9:    u = '{OP_MUL,  SRC_H,    SRC_T1, DST_KY};
            5'd10:   u = '{OP_MUL,  SRC_H,    SRC_T2, DST_KZ};
            5'd11:   u = '{OP_ADDH, SRC_X,    SRC_KX, DST_PX};
            5'd12:   u = '{OP_ADDH, SRC_Y,    SRC_KY, DST_PY};
            5'd13:   u = '{OP_ADDH, SRC_Z,    SRC_KZ, DST_PZ};
            5'd14:   u = '{OP_SUB,  SRC_PY,   SRC_PX, DST_T0};
            5'd15:   u = '{OP_MUL,  SRC_SIG,  SRC_T0, DST_T0};
            5'd16:   u = '{OP_SUB,  SRC_RHO,  SRC_PZ, DST_T1};
            5'd17:   u = '{OP_MUL,  SRC_T1,   SRC_PX, DST_T1};
            5'd18:   u = '{OP_SUB,  SRC_T1,   SRC_PY, DST_T1};
            5'd19:   u = '{OP_MUL,  SRC_PX,   SRC_PY, DST_T2};
            5'd20:   u = '{OP_MUL,  SRC_BETA, SRC_PZ, DST_KZ};
            5'd21:   u = '{OP_SUB,  SRC_T2,   SRC_KZ, DST_T2};
            5'd22:   u = '{OP_MUL,  SRC_H,    SRC_T0, DST_KX};
            5'd23:   u = '{OP_MUL,  SRC_H,    SRC_T1, DST_KY};
            5'd24:   u = '{OP_MUL,  SRC_H,    SRC_T2, DST_KZ};
            5'd25:   u = '{OP_ADD,  SRC_X,    SRC_KX, DST_X};
            5'd26:   u = '{OP_ADD,  SRC_Y,    SRC_KY, DST_Y};
            5'd27:   u = '{OP_ADD,  SRC_Z,    SRC_KZ, DST_Z};
            default: u = '{OP_ADD,  SRC_T0,   SRC_T0, DST_T0};
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/lorenz_rk2_stepper.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lorenz_rk2_stepper: Lorenz system, one RK2 midpoint step per transaction
// Q10.22 state x, y, z and elapsed time, advanced by a shared arithmetic unit.
// ---------------------------------------------------------------------------
// Usage:
//  - Slave stream: s_axis_tdata[0] = restart. A restart transaction reloads
//    x, y, z from the start registers and zeroes time; otherwise the state
//    advances by one midpoint step of size h.
//  - Master stream: one result per input transaction: new x, y, z, time and
//    a saturation flag in tuser (set if any sum, product or time clamped).
//  - Step transaction: the microcode runs on the single multiply/add unit
//    (two slope evaluations of 11 ops, 3 midpoint ops, 3 update ops), then
//    the result is registered. No new transaction is taken until the result
//    has moved into the output register. A restart transaction skips the
//    program and goes straight to the output register.
//  - s_axis_tready is high only between steps; the next item may be taken
//    while the previous result still waits in the output register.
//  - When the receiver stalls, a finished step holds in the sequencer until
//    the output register frees up; no result is dropped.
//  - APB registers at 4*i: sigma, rho, beta, h, start x, y, z. Write only
//    while idle. pready is always high.
//  - Reset (synchronous): registers to defaults (sigma 10, rho 40, beta
//    2.67, h 0.002, start 0.01/0.01/0), state to the start values, time 0.
// ---------------------------------------------------------------------------
module lorenz_rk2_stepper (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [0] restart
    // master stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [127:0]                   m_axis_tdata,   // x, y, z, time (31b), pad
    output logic [0:0]                     m_axis_tuser,   // [0] saturated
    // APB configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lrk_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import lrk_pkg::*;

    typedef logic signed [WORD_BITS-1:0] t_word;

    // configuration
    t_word                r_sigma, r_rho, r_beta, r_start_x, r_start_y, r_start_z;
    logic [TIME_BITS-1:0] r_step;

    // working state
    t_word                r_x, r_y, r_z, r_px, r_py, r_pz;
    t_word                r_t0, r_t1, r_t2, r_kx, r_ky, r_kz;
    logic [TIME_BITS-1:0] r_time;
    logic                 r_sat;

    // output register
    logic                 r_out_valid;
    t_word                r_out_x, r_out_y, r_out_z;
    logic [TIME_BITS-1:0] r_out_time;
    logic                 r_out_sat;

    t_seq_ctl             ctl;
    t_word                opa, opb, alu_y;
    logic                 alu_sat;
    logic                 in_fire, cfg_wr, out_free;
    logic [TIME_BITS:0]   time_sum;
    logic                 time_ovf;
    logic [TIME_BITS-1:0] n_time;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    lrk_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_fire),
        .i_restart  (s_axis_tdata[0]),
        .i_out_free (out_free),
        .o_ctl      (ctl)
    );

    assign s_axis_tready = ctl.ready;

    // operand fetch
    function automatic t_word pick(input t_src s, input t_word x, input t_word y,
                                   input t_word z, input t_word px, input t_word py,
                                   input t_word pz, input t_word t0, input t_word t1,
                                   input t_word t2, input t_word kx, input t_word ky,
                                   input t_word kz, input t_word sg, input t_word rh,
                                   input t_word bt, input logic [TIME_BITS-1:0] h);
        t_word v;
        unique case (s)
            SRC_X:    v = x;
            SRC_Y:    v = y;
            SRC_Z:    v = z;
            SRC_PX:   v = px;
            SRC_PY:   v = py;
            SRC_PZ:   v = pz;
            SRC_T0:   v = t0;
            SRC_T1:   v = t1;
            SRC_T2:   v = t2;
            SRC_KX:   v = kx;
            SRC_KY:   v = ky;
            SRC_KZ:   v = kz;
            SRC_SIG:  v = sg;
            SRC_RHO:  v = rh;
            SRC_BETA: v = bt;
            SRC_H:    v = $signed({1'b0, h});
        endcase
        return v;
    endfunction

    always_comb begin
        opa = pick(ctl.uop.a, r_x, r_y, r_z, r_px, r_py, r_pz, r_t0, r_t1, r_t2,
                   r_kx, r_ky, r_kz, r_sigma, r_rho, r_beta, r_step);
        opb = pick(ctl.uop.b, r_x, r_y, r_z, r_px, r_py, r_pz, r_t0, r_t1, r_t2,
                   r_kx, r_ky, r_kz, r_sigma, r_rho, r_beta, r_step);
    end

    lrk_alu u_alu (
        .i_op  (ctl.uop.op),
        .i_a   (opa),
        .i_b   (opb),
        .o_y   (alu_y),
        .o_sat (alu_sat)
    );

    // elapsed time: clamps once less than h of headroom remains
    always_comb begin
        time_sum = {1'b0, r_time} + {1'b0, r_step};
        time_ovf = time_sum > {1'b0, TIME_LIMIT};
        n_time   = time_ovf ? TIME_LIMIT : time_sum[TIME_BITS-1:0];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sigma   <= RST_SIGMA;
            r_rho     <= RST_RHO;
            r_beta    <= RST_BETA;
            r_step    <= RST_STEP;
            r_start_x <= RST_X;
            r_start_y <= RST_Y;
            r_start_z <= RST_Z;
        end else if (cfg_wr) begin
            unique case (paddr[ADDR_BITS-1:2])
                REG_SIGMA:   r_sigma   <= pwdata[WORD_BITS-1:0];
                REG_RHO:     r_rho     <= pwdata[WORD_BITS-1:0];
                REG_BETA:    r_beta    <= pwdata[WORD_BITS-1:0];
                REG_STEP:    r_step    <= pwdata[TIME_BITS-1:0];
                REG_START_X: r_start_x <= pwdata[WORD_BITS-1:0];
                REG_START_Y: r_start_y <= pwdata[WORD_BITS-1:0];
                REG_START_Z: r_start_z <= pwdata[WORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[ADDR_BITS-1:2])
            REG_SIGMA:   prdata = r_sigma;
            REG_RHO:     prdata = r_rho;
            REG_BETA:    prdata = r_beta;
            REG_STEP:    prdata = {1'b0, r_step};
            REG_START_X: prdata = r_start_x;
            REG_START_Y: prdata = r_start_y;
            REG_START_Z: prdata = r_start_z;
            default:     prdata = '0;
        endcase
    end

    // state, time and saturation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x    <= RST_X;
            r_y    <= RST_Y;
            r_z    <= RST_Z;
            r_time <= '0;
            r_sat  <= 1'b0;
        end else if (in_fire) begin
            r_sat <= 1'b0;
            if (s_axis_tdata[0]) begin
                r_x    <= r_start_x;
                r_y    <= r_start_y;
                r_z    <= r_start_z;
                r_time <= '0;
            end
        end else if (ctl.exec) begin
            r_sat <= r_sat | alu_sat | (ctl.last & time_ovf);
            if (ctl.last) begin
                r_time <= n_time;
            end
            unique case (ctl.uop.d)
                DST_X:   r_x <= alu_y;
                DST_Y:   r_y <= alu_y;
                DST_Z:   r_z <= alu_y;
                default: ;
            endcase
        end
    end

    // scratch registers (no reset needed)
    always_ff @(posedge i_clk) begin
        if (ctl.exec) begin
            unique case (ctl.uop.d)
                DST_PX:  r_px <= alu_y;
                DST_PY:  r_py <= alu_y;
                DST_PZ:  r_pz <= alu_y;
                DST_T0:  r_t0 <= alu_y;
                DST_T1:  r_t1 <= alu_y;
                DST_T2:  r_t2 <= alu_y;
                DST_KX:  r_kx <= alu_y;
                DST_KY:  r_ky <= alu_y;
                DST_KZ:  r_kz <= alu_y;
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.emit) begin
            r_out_x    <= r_x;
            r_out_y    <= r_y;
            r_out_z    <= r_z;
            r_out_time <= r_time;
            r_out_sat  <= r_sat;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_time, r_out_z, r_out_y, r_out_x};
    assign m_axis_tuser  = r_out_sat;

`ifndef SYNTHESIS
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_time <= TIME_LIMIT)
        else $error("elapsed time above limit");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.emit |-> (!r_out_valid || m_axis_tready))
        else $error("result emitted over an untaken result");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.exec |-> !s_axis_tready)
        else $error("input taken while stepping");

    a_restart_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && s_axis_tdata[0]) |=> (r_x == $past(r_start_x) && r_time == '0))
        else $error("restart did not reload state");
`endif

endmodule
`default_nettype wire

>>> rtl/core/lrk_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lrk_alu: shared saturating fixed-point unit
// Add, subtract, add-half and floor-rounded Q multiply, clamped to one word.
// ---------------------------------------------------------------------------
module lrk_alu (
    input  lrk_pkg::t_op                          i_op,
    input  logic signed [lrk_pkg::WORD_BITS-1:0]  i_a,
    input  logic signed [lrk_pkg::WORD_BITS-1:0]  i_b,
    output logic signed [lrk_pkg::WORD_BITS-1:0]  o_y,
    output logic                                  o_sat
);
    import lrk_pkg::*;

    logic signed [2*WORD_BITS-1:0] prod;
    logic signed [2*WORD_BITS-1:0] wide;
    logic signed [WORD_BITS-1:0]   half;
    logic signed [WORD_BITS:0]     sum;

    always_comb begin
        prod = i_a * i_b;
        half = i_b >>> 1;                 // floor halving
        sum  = '0;
        wide = '0;
        unique case (i_op)
            OP_ADD:  sum = i_a + i_b;
            OP_SUB:  sum = i_a - i_b;
            OP_ADDH: sum = i_a + half;
            OP_MUL:  sum = '0;
        endcase
        if (i_op == OP_MUL) begin
            wide = prod >>> FRAC_BITS;    // arithmetic shift = floor
        end else begin
            wide = sum;
        end
        o_sat = 1'b0;
        if (wide > WORD_MAX) begin
            o_y   = WORD_MAX;
            o_sat = 1'b1;
        end else if (wide < WORD_MIN) begin
            o_y   = WORD_MIN;
            o_sat = 1'b1;
        end else begin
            o_y = wide[WORD_BITS-1:0];
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/lrk_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lrk_seq: step sequencer
// Walks the microcode once per step transaction (not on restart), then hands off.
// ---------------------------------------------------------------------------
module lrk_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_restart,
    input  logic              i_out_free,
    output lrk_pkg::t_seq_ctl o_ctl
);
    import lrk_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} t_state;

    localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(UCODE_LEN - 1);

    t_state               r_state;
    logic [STEP_BITS-1:0] r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_step <= '0;
                    if (i_start) begin
                        r_state <= i_restart ? S_DONE : S_RUN;
                    end
                end
                S_RUN: begin
                    if (r_step == LAST_STEP) begin
                        r_state <= S_DONE;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_DONE: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_ctl.ready = (r_state == S_IDLE);
        o_ctl.exec  = (r_state == S_RUN);
        o_ctl.last  = (r_state == S_RUN) && (r_step == LAST_STEP);
        o_ctl.emit  = (r_state == S_DONE) && i_out_free;
        o_ctl.uop   = ucode(r_step);
    end

endmodule
`default_nettype wire

>>> bench/lorenz_rk2_stepper_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lorenz_rk2_stepper_tb: self-checking bench for the Lorenz RK2 stepper
// Drives tick and restart transactions with random gaps and back-pressure,
// reprograms the coefficient registers between phases, and compares every
// result with a fixed-point midpoint predictor kept in a scoreboard.
// ---------------------------------------------------------------------------
module lorenz_rk2_stepper_tb;
    import lrk_pkg::*;

    // fixed-point bounds of the Q10.22 word and the elapsed-time limit
    localparam longint WORD_TOP    = (longint'(1) <<< (WORD_BITS - 1)) - 1;
    localparam longint WORD_BOTTOM = -WORD_TOP - 1;
    localparam longint TIME_TOP    = (longint'(1) <<< (TIME_BITS - 1)) - 1;
    localparam longint UNIT        = longint'(1) <<< FRAC_BITS;

    // address one past the register map, writes there must be ignored
    localparam logic [IDX_BITS-1:0] SPARE_REG = IDX_BITS'(CFG_COUNT);

    localparam int PHASES          = 12;
    localparam int TICKS_PER_PHASE = 140;
    localparam int LONG_HOLD       = 300;  // sink stall, cycles
    localparam int DRAIN_SLACK     = 4;
    localparam int STEP_LATENCY    = 40;

    typedef struct {
        logic signed [WORD_BITS-1:0] x;
        logic signed [WORD_BITS-1:0] y;
        logic signed [WORD_BITS-1:0] z;
        logic [TIME_BITS-1:0]        t;
        logic                        sat;
    } t_lorenz_point;

    // -----------------------------------------------------------------------
    // Scoreboard: midpoint predictor plus the queue of expected points
    // -----------------------------------------------------------------------
    class trajectory_scoreboard;
        longint sigma, rho, beta, step_h;
        longint start_x, start_y, start_z;
        longint x_now, y_now, z_now, t_now;
        bit     clamped;
        int     errors;
        t_lorenz_point expected_points[$];

        function new();
            sigma   = 41943040;     // 10
            rho     = 167772160;    // 40
            beta    = 11198792;     // 2.67
            step_h  = 8389;         // 0.002
            start_x = 41943;        // 0.01
            start_y = 41943;
            start_z = 0;
            x_now   = start_x;
            y_now   = start_y;
            z_now   = start_z;
            t_now   = 0;
            errors  = 0;
        endfunction

        function void apply_setting(logic [IDX_BITS-1:0] idx, logic [31:0] value);
            case (idx)
                REG_SIGMA:   sigma   = longint'($signed(value));
                REG_RHO:     rho     = longint'($signed(value));
                REG_BETA:    beta    = longint'($signed(value));
                REG_STEP:    step_h  = longint'(value[TIME_BITS-1:0]);  // top bit dropped
                REG_START_X: start_x = longint'($signed(value));
                REG_START_Y: start_y = longint'($signed(value));
                REG_START_Z: start_z = longint'($signed(value));
                default: ;
            endcase
        endfunction

        // clamp to the word range, remembering that it happened
        function longint fit(longint v);
            if (v > WORD_TOP) begin
                clamped = 1'b1;
                return WORD_TOP;
            end
            if (v < WORD_BOTTOM) begin
                clamped = 1'b1;
                return WORD_BOTTOM;
            end
            return v;
        endfunction

        // operands are word-sized, so the exact product fits in 64 bits;
        // arithmetic shift gives the floor rounding
        function longint mul_q(longint a, longint b);
            return fit((a * b) >>> FRAC_BITS);
        endfunction

        function void slope(input longint x, y, z, output longint kx, ky, kz);
            longint dx, dy, dz;
            dx = mul_q(sigma, fit(y - x));
            dy = fit(mul_q(fit(rho - z), x) - y);
            dz = fit(mul_q(x, y) - mul_q(beta, z));
            kx = mul_q(step_h, dx);
            ky = mul_q(step_h, dy);
            kz = mul_q(step_h, dz);
        endfunction

        function void note_tick(bit restart);
            t_lorenz_point p;
            longint k1x, k1y, k1z, k2x, k2y, k2z, mx, my, mz;
            clamped = 1'b0;
            if (restart) begin
                x_now = start_x;
                y_now = start_y;
                z_now = start_z;
                t_now = 0;
            end else begin
                slope(x_now, y_now, z_now, k1x, k1y, k1z);
                mx = fit(x_now + (k1x >>> 1));
                my = fit(y_now + (k1y >>> 1));
                mz = fit(z_now + (k1z >>> 1));
                slope(mx, my, mz, k2x, k2y, k2z);
                x_now = fit(x_now + k2x);
                y_now = fit(y_now + k2y);
                z_now = fit(z_now + k2z);
                // time sticks at its limit once less than h of headroom is left
                if (t_now > TIME_TOP - step_h) begin
                    t_now   = TIME_TOP;
                    clamped = 1'b1;
                end else begin
                    t_now += step_h;
                end
            end
            p.x   = WORD_BITS'(x_now);
            p.y   = WORD_BITS'(y_now);
            p.z   = WORD_BITS'(z_now);
            p.t   = TIME_BITS'(t_now);
            p.sat = clamped;
            expected_points.push_back(p);
        endfunction

        function void compare_field(string name, logic signed [63:0] want,
                                    logic signed [63:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_point(logic [127:0] data, logic sat);
            t_lorenz_point want;
            if (expected_points.size() == 0) begin
                $error("result transaction with no tick pending: data %h", data);
                errors++;
                return;
            end
            want = expected_points.pop_front();
            compare_field("x_out", want.x, $signed(data[31:0]));
            compare_field("y_out", want.y, $signed(data[63:32]));
            compare_field("z_out", want.z, $signed(data[95:64]));
            compare_field("time_out", {1'b0, want.t}, {1'b0, data[126:96]});
            compare_field("saturated", {1'b0, want.sat}, {1'b0, sat});
        endfunction

        function int pending();
            return expected_points.size();
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // -----------------------------------------------------------------------
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = '0;     // [0] restart, [7:1] zero
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [127:0]         m_axis_tdata;          // x, y, z, time (31b), pad
    logic [0:0]           m_axis_tuser;          // [0] saturated
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    trajectory_scoreboard sb;
    bit quiet_tail    = 1'b0;   // no idling on either side
    bit long_hold_req = 1'b0;   // ask the sink for one long stall

    lorenz_rk2_stepper uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin : clock_gen
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Result sink: random stall bursts, stretches of steady ready, and one
    // long hold-off on request so the stepper backs up into its input.
    initial begin : result_sink
        forever begin
            if (long_hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_req = 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // Outputs are sampled at the edge, before the DUT updates them.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_point(m_axis_tdata, m_axis_tuser[0]);
    end

    // -----------------------------------------------------------------------
    // Drivers
    // -----------------------------------------------------------------------
    // APB write: setup then access. psel stays up between back-to-back
    // writes; apb_release drops it once the group is done.
    task automatic write_cfg(input logic [IDX_BITS-1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.apply_setting(idx, value);
    endtask

    task automatic apb_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offer one tick or restart; tvalid stays high on return so the next
    // transaction can follow back to back.
    task automatic send_tick(input bit restart);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, restart};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_tick(restart);
    endtask

    // Stop offering and wait until every expected point has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    // Mostly a value in [lo, hi], now and then any word at all.
    function automatic logic [31:0] pick_word(longint lo, longint hi);
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return 32'(lo + longint'($urandom_range(0, 32'(hi - lo))));
    endfunction

    task automatic run_ticks(input int count);
        send_tick(1'b1);    // pick up the start values first
        repeat (count - 1)
            send_tick($urandom_range(0, 19) == 0);
    endtask

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    initial begin : stimulus
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults straight out of reset: state starts at the start values
        repeat (3) send_tick(1'b0);
        send_tick(1'b1);
        repeat (3) send_tick(1'b0);
        drain();

        // largest magnitudes: sums and products clamp; h beyond half the
        // time range saturates time on the first tick. Bit 31 of the step
        // write is dropped, and the write past the map is ignored.
        write_cfg(REG_SIGMA,   32'h7FFF_FFFF);
        write_cfg(REG_RHO,     32'h8000_0000);
        write_cfg(REG_BETA,    32'h7FFF_FFFF);
        write_cfg(REG_STEP,    32'hFFFF_FFFF);
        write_cfg(REG_START_X, 32'h7FFF_FFFF);
        write_cfg(REG_START_Y, 32'h8000_0000);
        write_cfg(REG_START_Z, 32'h7FFF_FFFF);
        write_cfg(SPARE_REG,   32'h1234_5678);
        apb_release();
        send_tick(1'b1);
        repeat (4) send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        drain();

        // most negative sigma and beta, zero rho and step: time stays at zero while
        // the slopes still clamp; negative products round toward -inf
        write_cfg(REG_SIGMA,   32'h8000_0000);
        write_cfg(REG_RHO,     32'h0000_0000);
        write_cfg(REG_BETA,    32'h8000_0000);
        write_cfg(REG_STEP,    32'h0000_0000);
        write_cfg(REG_START_X, 32'hFFFF_FFFF);
        write_cfg(REG_START_Y, 32'h0000_0000);
        write_cfg(REG_START_Z, 32'h8000_0000);
        apb_release();
        send_tick(1'b1);
        repeat (3) send_tick(1'b0);
        drain();

        // the rho = 40.000000001 run: that value rounds to the code for 40
        write_cfg(REG_SIGMA,   32'(10 * UNIT));
        write_cfg(REG_RHO,     32'd167772160);
        write_cfg(REG_BETA,    32'd11184811);          // 8/3
        write_cfg(REG_STEP,    32'd41943);             // 0.01
        write_cfg(REG_START_X, 32'(-(3 * UNIT) / 2));
        write_cfg(REG_START_Y, 32'(9 * UNIT / 4));
        write_cfg(REG_START_Z, 32'(30 * UNIT));
        apb_release();
        send_tick(1'b1);
        repeat (5) send_tick(1'b0);
        drain();

        // random phases: new settings, then a restart and a long run of ticks
        for (int ph = 0; ph < PHASES; ph++) begin
            if ($urandom_range(0, 3) != 0) write_cfg(REG_SIGMA, pick_word(-2 * UNIT, 20 * UNIT));
            if ($urandom_range(0, 3) != 0) write_cfg(REG_RHO,   pick_word(0, 60 * UNIT));
            if ($urandom_range(0, 3) != 0) write_cfg(REG_BETA,  pick_word(0, 5 * UNIT));
            if ($urandom_range(0, 3) != 0) write_cfg(REG_STEP,  pick_word(0, UNIT / 40));
            if ($urandom_range(0, 3) != 0)
                write_cfg(REG_START_X, pick_word(-20 * UNIT, 20 * UNIT));
            if ($urandom_range(0, 3) != 0)
                write_cfg(REG_START_Y, pick_word(-20 * UNIT, 20 * UNIT));
            if ($urandom_range(0, 3) != 0)
                write_cfg(REG_START_Z, pick_word(-5 * UNIT, 50 * UNIT));
            if ($urandom_range(0, 7) == 0) write_cfg(SPARE_REG, $urandom);
            apb_release();

            if (ph == 2)
                long_hold_req = 1'b1;   // sender keeps offering meanwhile
            if (ph == PHASES - 1)
                quiet_tail = 1'b1;
            run_ticks(TICKS_PER_PHASE);
            drain();
        end

        repeat (STEP_LATENCY) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d expected points never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
